// ===== src/dual_stack_with_merge_unit_defines.svh =====
// Assertion macros shared by the dual stack unit modules.
`ifndef DUAL_STACK_WITH_MERGE_UNIT_DEFINES_SVH
`define DUAL_STACK_WITH_MERGE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dsm_pkg.sv =====
// Shared codes and controller/datapath interface types for the dual stack unit.
package dsm_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int WORD_W   = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FIRST  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FIRST   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_SECOND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_SECOND  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_VIEW        = 3'd4;
    localparam logic [CMD_W-1:0] CMD_UNIFY       = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LISTED = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic                load;
        logic                push_first;
        logic                push_second;
        logic                pop_first;
        logic                pop_second;
        logic                idx_load;
        logic                idx_side;
        logic                idx_dec;
        logic                rd_list;
        logic                merge_rd;
        logic                merge_wr;
        logic                emit;
        logic                emit_elem;
        logic                emit_which;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_last;
    } dsm_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             first_empty;
        logic             second_empty;
        logic             first_full;
        logic             second_full;
        logic             merge_over;
        logic             idx_zero;
        logic             idx_one;
        logic             side;
        logic             out_free;
    } dsm_stat_t;

endpackage

// ===== src/dsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dsm_datapath.sv =====
// Datapath: stack memories, counts, list index and result output register.
`include "dual_stack_with_merge_unit_defines.svh"

module dsm_datapath #(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dsm_pkg::dsm_ctl_t                  ctl,
    output dsm_pkg::dsm_stat_t                 stat,
    input  logic [dsm_pkg::CMD_W-1:0]          command,
    input  logic signed [dsm_pkg::WORD_W-1:0]  push_value,
    input  logic                               res_stall,
    output logic                               res_valid,
    output logic signed [dsm_pkg::WORD_W-1:0]  element,
    output logic                               which_stack,
    output logic [dsm_pkg::STATUS_W-1:0]       status,
    output logic                               last
);
    import dsm_pkg::*;

    logic [CMD_W-1:0]         cmd_reg;
    logic [WORD_W-1:0]        val_reg;
    logic [CW-1:0]            first_count_reg, first_count_next;
    logic [CW-1:0]            second_count_reg, second_count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic                     side_reg, side_next;
    logic                     res_valid_reg;
    logic signed [WORD_W-1:0] elem_reg;
    logic                     which_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic                     last_reg;

    logic [CW-1:0]     idx_m1;
    logic [CW-1:0]     second_m1;
    logic [WORD_W-1:0] first_rdata;
    logic [WORD_W-1:0] second_rdata;
    logic              out_free;

    assign idx_m1    = idx_reg - CW'(1);
    assign second_m1 = second_count_reg - CW'(1);
    assign out_free  = !res_valid_reg || !res_stall;

    // Stack memories
    dsm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_first_ram (
        .clk   (clk),
        .we    (ctl.push_first || ctl.merge_wr),
        .waddr (first_count_reg[AW-1:0]),
        .wdata (ctl.merge_wr ? second_rdata : val_reg),
        .re    (ctl.rd_list && !side_reg),
        .raddr (idx_m1[AW-1:0]),
        .rdata (first_rdata)
    );

    dsm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_second_ram (
        .clk   (clk),
        .we    (ctl.push_second),
        .waddr (second_count_reg[AW-1:0]),
        .wdata (val_reg),
        .re    ((ctl.rd_list && side_reg) || ctl.merge_rd),
        .raddr (ctl.merge_rd ? second_m1[AW-1:0] : idx_m1[AW-1:0]),
        .rdata (second_rdata)
    );

    // Count and list index updates
    always_comb
    begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        idx_next          = idx_reg;
        side_next         = side_reg;
        if (ctl.push_first || ctl.merge_wr)
        begin
            first_count_next = first_count_reg + CW'(1);
        end
        else if (ctl.pop_first)
        begin
            first_count_next = first_count_reg - CW'(1);
        end
        if (ctl.push_second)
        begin
            second_count_next = second_count_reg + CW'(1);
        end
        else if (ctl.pop_second || ctl.merge_wr)
        begin
            second_count_next = second_m1;
        end
        if (ctl.idx_load)
        begin
            idx_next  = ctl.idx_side ? second_count_reg : first_count_reg;
            side_next = ctl.idx_side;
        end
        else if (ctl.idx_dec)
        begin
            idx_next = idx_m1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            idx_reg          <= '0;
            side_reg         <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            idx_reg          <= idx_next;
            side_reg         <= side_next;
            if (ctl.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Command capture and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= command;
            val_reg <= push_value;
        end
        if (ctl.emit)
        begin
            if (ctl.emit_elem)
            begin
                elem_reg <= $signed(side_reg ? second_rdata : first_rdata);
            end
            else
            begin
                elem_reg <= '0;
            end
            which_reg  <= ctl.emit_which;
            status_reg <= ctl.emit_status;
            last_reg   <= ctl.emit_last;
        end
    end

    // Status to controller
    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.first_empty  = (first_count_reg == '0);
        stat.second_empty = (second_count_reg == '0);
        stat.first_full   = (first_count_reg == CW'(DEPTH));
        stat.second_full  = (second_count_reg == CW'(DEPTH));
        stat.merge_over   = (({1'b0, first_count_reg} + {1'b0, second_count_reg})
                             > (CW + 1)'(DEPTH));
        stat.idx_zero     = (idx_reg == '0);
        stat.idx_one      = (idx_reg == CW'(1));
        stat.side         = side_reg;
        stat.out_free     = out_free;
    end

    assign res_valid   = res_valid_reg;
    assign element     = elem_reg;
    assign which_stack = which_reg;
    assign status      = status_reg;
    assign last        = last_reg;

    // Checks
    `DSM_ASSERT_NOW(a_count_bound, 1'b1, (first_count_reg <= CW'(DEPTH)) && (second_count_reg <= CW'(DEPTH)), "stack count above depth")
    `DSM_ASSERT_NOW(a_emit_free, ctl.emit, out_free, "result emitted over a held transaction")
    `DSM_ASSERT_NOW(a_merge_nonempty, ctl.merge_wr, second_count_reg != '0, "merge move from empty second stack")

endmodule

// ===== src/dsm_ctrl.sv =====
// Controller state machine: sequences push, pop, view and unify commands.
`include "dual_stack_with_merge_unit_defines.svh"

module dsm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  dsm_pkg::dsm_stat_t  stat,
    output dsm_pkg::dsm_ctl_t   ctl
);
    import dsm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_LRD  = 3'd2;
    localparam logic [2:0] S_LEM  = 3'd3;
    localparam logic [2:0] S_MRD  = 3'd4;
    localparam logic [2:0] S_MWR  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       last_side;

    // View lists both stacks; unify lists only the first
    assign last_side = (stat.cmd == CMD_VIEW) ? stat.side : 1'b1;
    assign cmd_stall = (state_reg != S_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.cmd)
                    CMD_PUSH_FIRST, CMD_POP_FIRST, CMD_PUSH_SECOND, CMD_POP_SECOND:
                    begin
                        if (stat.out_free)
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_last   = 1'b1;
                            ctl.emit_status = ST_DONE;
                            state_next      = S_IDLE;
                            if (stat.cmd == CMD_PUSH_FIRST)
                            begin
                                if (stat.first_full)
                                    ctl.emit_status = ST_OVER;
                                else
                                    ctl.push_first = 1'b1;
                            end
                            else if (stat.cmd == CMD_POP_FIRST)
                            begin
                                if (stat.first_empty)
                                    ctl.emit_status = ST_UNDER;
                                else
                                    ctl.pop_first = 1'b1;
                            end
                            else if (stat.cmd == CMD_PUSH_SECOND)
                            begin
                                ctl.emit_which = 1'b1;
                                if (stat.second_full)
                                    ctl.emit_status = ST_OVER;
                                else
                                    ctl.push_second = 1'b1;
                            end
                            else
                            begin
                                ctl.emit_which = 1'b1;
                                if (stat.second_empty)
                                    ctl.emit_status = ST_UNDER;
                                else
                                    ctl.pop_second = 1'b1;
                            end
                        end
                    end
                    CMD_VIEW:
                    begin
                        ctl.idx_load = 1'b1;
                        ctl.idx_side = 1'b0;
                        state_next   = S_LRD;
                    end
                    CMD_UNIFY:
                    begin
                        if (stat.merge_over)
                        begin
                            if (stat.out_free)
                            begin
                                ctl.emit        = 1'b1;
                                ctl.emit_status = ST_OVER;
                                ctl.emit_last   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = S_MRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LRD:
            begin
                if (stat.idx_zero)
                begin
                    // Empty stack: one status transaction
                    if (stat.out_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_which  = stat.side;
                        ctl.emit_status = ST_EMPTY;
                        ctl.emit_last   = last_side;
                        if (last_side)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ctl.idx_load = 1'b1;
                            ctl.idx_side = 1'b1;
                        end
                    end
                end
                else
                begin
                    ctl.rd_list = 1'b1;
                    state_next  = S_LEM;
                end
            end
            S_LEM:
            begin
                if (stat.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_elem   = 1'b1;
                    ctl.emit_which  = stat.side;
                    ctl.emit_status = ST_LISTED;
                    ctl.emit_last   = last_side && stat.idx_one;
                    ctl.idx_dec     = 1'b1;
                    state_next      = S_LRD;
                    if (stat.idx_one)
                    begin
                        if (last_side)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ctl.idx_load = 1'b1;
                            ctl.idx_side = 1'b1;
                        end
                    end
                end
            end
            S_MRD:
            begin
                if (stat.second_empty)
                begin
                    ctl.idx_load = 1'b1;
                    ctl.idx_side = 1'b0;
                    state_next   = S_LRD;
                end
                else
                begin
                    ctl.merge_rd = 1'b1;
                    state_next   = S_MWR;
                end
            end
            S_MWR:
            begin
                ctl.merge_wr = 1'b1;
                state_next   = S_MRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Checks
    `DSM_ASSERT_NOW(a_lem_index, state_reg == S_LEM, !stat.idx_zero, "listing with zero index")
    `DSM_ASSERT_NOW(a_second_view_only, (state_reg == S_LRD) && stat.side, stat.cmd == CMD_VIEW, "second stack listed outside view")
    `DSM_ASSERT_NOW(a_unify_drained, (state_reg == S_LRD) && (stat.cmd == CMD_UNIFY), stat.second_empty, "unify listing before merge finished")

endmodule

// ===== src/dual_stack_with_merge_unit.sv =====
// Dual stack unit top level: two memory-backed stacks with push, pop, view and unify.
// Push/pop: one transaction, emitted from the execute state once the output is free.
// View: accept and decode, then read and emit each listed word; an empty stack gives one status.
// Unify: accept, move each word of stack two onto stack one (read then write), see stack two drained,
// then list stack one as view does; a refused unify is one transaction like push/pop. Stalls add cycles.
// Reset is asynchronous active low: counts and control clear, memory contents stay undefined.
module dual_stack_with_merge_unit #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [dsm_pkg::CMD_W-1:0]          command,
    input  logic signed [dsm_pkg::WORD_W-1:0]  push_value,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic signed [dsm_pkg::WORD_W-1:0]  element,
    output logic                               which_stack,
    output logic [dsm_pkg::STATUS_W-1:0]       status,
    output logic                               last
);
    import dsm_pkg::*;

    dsm_ctl_t  ctl;
    dsm_stat_t stat;

    // Sequencer
    dsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Storage and result path
    dsm_datapath #(.DEPTH(DEPTH)) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .command     (command),
        .push_value  (push_value),
        .res_stall   (res_stall),
        .res_valid   (res_valid),
        .element     (element),
        .which_stack (which_stack),
        .status      (status),
        .last        (last)
    );

endmodule
